// ===== rtl/core/slip_driven_emission_accumulator_core_assert.svh =====
// assertion macros for the slip driven emission accumulator
`ifndef SLIP_DRIVEN_EMISSION_ACCUMULATOR_CORE_ASSERT_SVH
`define SLIP_DRIVEN_EMISSION_ACCUMULATOR_CORE_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define SDEA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define SDEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sdea_pkg.sv =====
// shared types and constants of the slip driven emission accumulator
`default_nettype none

package sdea_pkg;

   localparam int DEFAULT_EMITTER_COUNT = 64;
   localparam int DEFAULT_MAX_PUFFS = 6;

   localparam int INDEX_W = 6;
   localparam int Q15_W = 16;
   localparam int RAMP_W = 15;
   localparam int CREDIT_W = 24;
   localparam int INCREMENT_W = 26;
   localparam int COUNT_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int COUNT_FIELD_MAX = 7;

   localparam logic [Q15_W-1:0] Q15_ONE = 16'd32768;
   localparam logic [Q15_W-1:0] Q15_SMALL = 16'd327;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLIP_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_SCALE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPAWN_RATE = 2'd3;

   localparam logic RESET_ENABLE = 1'b1;
   localparam logic [Q15_W-1:0] RESET_SLIP_THRESHOLD = 16'd9830;
   localparam logic [RAMP_W-1:0] RESET_RAMP_SCALE = 15'd366;
   localparam logic [Q15_W-1:0] RESET_SPAWN_RATE = 16'd2560;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAMP,
      ST_SQUARE,
      ST_GAIN,
      ST_RATE,
      ST_TIME,
      ST_WRITE
   } sdea_state_type;

   typedef struct packed {
      logic [Q15_W-1:0]  diff;
      logic [RAMP_W-1:0] ramp;
      logic [Q15_W-1:0]  gain;
      logic [Q15_W-1:0]  rate;
      logic [Q15_W-1:0]  dt;
   } sdea_operand_type;

endpackage

`default_nettype wire

// ===== rtl/core/sdea_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module sdea_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sdea_arith.sv =====
// multiply chain from slip excess to credit increment, one product per cycle
`default_nettype none

module sdea_arith (
   input  wire logic                              clock,
   input  wire sdea_pkg::sdea_state_type          state,
   input  wire sdea_pkg::sdea_operand_type        operand,
   output logic [sdea_pkg::Q15_W-1:0]             strength,
   output logic [sdea_pkg::INCREMENT_W-1:0]       increment
);

   import sdea_pkg::*;

   logic [Q15_W-1:0]       intensity_ff;
   logic [Q15_W-1:0]       square_ff;
   logic [Q15_W-1:0]       strength_ff;
   logic [30:0]            rate_strength_ff;
   logic [INCREMENT_W-1:0] increment_ff;

   logic [30:0] ramp_prod;
   logic [22:0] ramp_shift;
   logic [31:0] square_prod;
   logic [31:0] gain_prod;
   logic [31:0] rate_prod;
   logic [46:0] time_prod;

   always_comb begin
      ramp_prod = 31'(operand.diff) * 31'(operand.ramp);
      ramp_shift = ramp_prod[30:8];
      square_prod = 32'(intensity_ff) * 32'(intensity_ff);
      gain_prod = 32'(square_ff) * 32'(operand.gain);
      rate_prod = 32'(operand.rate) * 32'(strength_ff);
      time_prod = 47'(rate_strength_ff) * 47'(operand.dt);
   end

   always_ff @(posedge clock) begin
      unique case (state)
         ST_RAMP: begin
            intensity_ff <= (ramp_shift > 23'(Q15_ONE)) ? Q15_ONE : ramp_shift[15:0];
         end
         ST_SQUARE: begin
            square_ff <= square_prod[30:15];
         end
         ST_GAIN: begin
            strength_ff <= gain_prod[30:15];
         end
         ST_RATE: begin
            rate_strength_ff <= rate_prod[30:0];
         end
         ST_TIME: begin
            increment_ff <= time_prod[46:21];
         end
         default: begin
         end
      endcase
   end

   assign strength = strength_ff;
   assign increment = increment_ff;

endmodule

`default_nettype wire

// ===== rtl/core/slip_driven_emission_accumulator_core.sv =====
// top level of the slip driven emission accumulator
`default_nettype none

// Each request names one wheel emitter and returns exactly one result, a puff count and
// a strength, on rsp_valid for one cycle; the receiver cannot hold results off. A request
// is taken when start is high and busy is low. Its result strobe rises in the cycle in which
// busy falls, and the next request can be taken in that cycle, so the block takes no new
// request before it is through with the last one. This comes from the chain of five
// registered multiplies (ramp, square, gain, rate, time) followed by the credit update,
// which reads the emitter's credit from a registered memory at acceptance and writes it
// back in the write state; busy stays high across the whole read-modify-write. The user must
// write configuration through csr_write_enable only while idle; the block does not check.
module slip_driven_emission_accumulator_core #(
   parameter int EMITTER_COUNT = sdea_pkg::DEFAULT_EMITTER_COUNT,
   parameter int MAX_PUFFS_PER_STEP = sdea_pkg::DEFAULT_MAX_PUFFS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [sdea_pkg::INDEX_W-1:0]     req_emitter_index,
   input  wire logic                             req_grounded,
   input  wire logic [sdea_pkg::Q15_W-1:0]       req_slip,
   input  wire logic [sdea_pkg::Q15_W-1:0]       req_gain,
   input  wire logic [sdea_pkg::Q15_W-1:0]       req_delta_time,
   output logic                                  rsp_valid,
   output logic [sdea_pkg::COUNT_W-1:0]          rsp_spawn_count,
   output logic [sdea_pkg::Q15_W-1:0]            rsp_strength,
   input  wire logic                             csr_write_enable,
   input  wire logic [sdea_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sdea_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   import sdea_pkg::*;

   localparam int INDEX_SPAN = 1 << INDEX_W;
   localparam int DEPTH = (EMITTER_COUNT < INDEX_SPAN) ? EMITTER_COUNT : INDEX_SPAN;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP = (MAX_PUFFS_PER_STEP < COUNT_FIELD_MAX) ?
                        MAX_PUFFS_PER_STEP : COUNT_FIELD_MAX;

   sdea_state_type state_ff, state_in;

   logic             enable_ff;
   logic [Q15_W-1:0]  slip_threshold_ff;
   logic [RAMP_W-1:0] ramp_scale_ff;
   logic [Q15_W-1:0]  spawn_rate_ff;

   logic [Q15_W-1:0]  diff_ff;
   logic [Q15_W-1:0]  gain_ff;
   logic [Q15_W-1:0]  dt_ff;
   logic              kill_ff;
   logic              clear_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              valid_rd_ff;
   logic [DEPTH-1:0]  valid_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_spawn_count_ff, rsp_spawn_count_in;
   logic [Q15_W-1:0]   rsp_strength_ff, rsp_strength_in;

   logic              accept;
   logic [ADDR_W-1:0] req_addr;
   logic [Q15_W-1:0]  gain_clamped;
   logic              req_kill;
   logic              req_clear;

   sdea_operand_type       operand;
   logic [Q15_W-1:0]       strength;
   logic [INCREMENT_W-1:0] increment;
   logic [CREDIT_W-1:0]    rd_data;

   logic [CREDIT_W-1:0] base;
   logic [26:0]         sum;
   logic [CREDIT_W-1:0] saturated;
   logic [7:0]          whole;
   logic [COUNT_W-1:0]  count;
   logic [CREDIT_W-1:0] remain;
   logic                faint;
   logic                wr_en;
   logic [CREDIT_W-1:0] wr_data;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign req_addr = req_emitter_index[ADDR_W-1:0];
   assign gain_clamped = (req_gain > Q15_ONE) ? Q15_ONE : req_gain;
   assign req_kill = !enable_ff || (req_delta_time == '0) ||
                     (int'(req_emitter_index) >= EMITTER_COUNT);
   assign req_clear = !req_grounded || (gain_clamped <= Q15_SMALL) ||
                      (req_slip < slip_threshold_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= RESET_ENABLE;
         slip_threshold_ff <= RESET_SLIP_THRESHOLD;
         ramp_scale_ff <= RESET_RAMP_SCALE;
         spawn_rate_ff <= RESET_SPAWN_RATE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE:         enable_ff <= csr_write_data[0];
            CSR_SLIP_THRESHOLD: slip_threshold_ff <= csr_write_data;
            CSR_RAMP_SCALE:     ramp_scale_ff <= csr_write_data[RAMP_W-1:0];
            CSR_SPAWN_RATE:     spawn_rate_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   state_in = accept ? ST_RAMP : ST_IDLE;
         ST_RAMP:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_GAIN;
         ST_GAIN:   state_in = ST_RATE;
         ST_RATE:   state_in = ST_TIME;
         ST_TIME:   state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         diff_ff <= req_slip - slip_threshold_ff;
         gain_ff <= gain_clamped;
         dt_ff <= req_delta_time;
         kill_ff <= req_kill;
         clear_ff <= req_clear;
         addr_ff <= req_addr;
         valid_rd_ff <= valid_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   always_comb begin
      operand.diff = diff_ff;
      operand.ramp = ramp_scale_ff;
      operand.gain = gain_ff;
      operand.rate = spawn_rate_ff;
      operand.dt = dt_ff;
   end

   sdea_arith u_arith (
      .clock     (clock),
      .state     (state_ff),
      .operand   (operand),
      .strength  (strength),
      .increment (increment)
   );

   sdea_ram #(
      .WIDTH (CREDIT_W),
      .DEPTH (DEPTH)
   ) u_credit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      base = valid_rd_ff ? rd_data : '0;
      sum = 27'(base) + 27'(increment);
      saturated = (sum > 27'(24'hFF_FFFF)) ? 24'hFF_FFFF : sum[CREDIT_W-1:0];
      whole = saturated[23:16];
      count = (whole > 8'(CAP)) ? COUNT_W'(CAP) : whole[COUNT_W-1:0];
      remain = saturated - {5'd0, count, 16'd0};
      faint = (strength <= Q15_SMALL);
      wr_en = (state_ff == ST_WRITE) && !kill_ff;
      wr_data = (clear_ff || faint) ? '0 : remain;

      rsp_valid_in = (state_ff == ST_WRITE);
      rsp_spawn_count_in = (kill_ff || clear_ff || faint) ? '0 : count;
      rsp_strength_in = (rsp_spawn_count_in == '0) ? '0 : strength;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_spawn_count_ff <= rsp_spawn_count_in;
      rsp_strength_ff <= rsp_strength_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_spawn_count = rsp_spawn_count_ff;
   assign rsp_strength = rsp_strength_ff;

`include "slip_driven_emission_accumulator_core_assert.svh"

   `SDEA_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "request not held busy")
   `SDEA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "result repeated")
   `SDEA_ASSERT_NEXT(a_write_strobe, clock, reset, state_ff == ST_WRITE, rsp_valid && !busy, "write without result")
   `SDEA_ASSERT_SAME(a_count_cap, clock, reset, rsp_valid, rsp_spawn_count <= COUNT_W'(CAP), "count beyond cap")
   `SDEA_ASSERT_SAME(a_puff_strength, clock, reset, rsp_valid && (rsp_spawn_count != '0), rsp_strength > Q15_SMALL, "puffs with faint strength")

endmodule

`default_nettype wire
